// ===== rtl/dd_lim_pkg.sv =====
// Shared types, constants and register codes for the wheel speed limiter.
`timescale 1ns / 1ps
package dd_lim_pkg;

  localparam int FIELD_W     = 24;
  localparam int SPEED_W     = 23;
  localparam int ACT_W       = 3;
  localparam int SEP_W       = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 23;
  localparam int RIM_W       = 27;
  localparam int VEL_W       = 30;
  localparam int FRAC_SHIFT  = 17;
  localparam int QUO_W       = SPEED_W + FRAC_SHIFT;
  localparam int DIV_STEPS   = QUO_W;
  localparam int DIV_CNT_W   = 6;

  localparam int MAX_PAIRS_DEF = 4;

  localparam logic [SPEED_W-1:0] SPEED_RST = 23'd65536;
  localparam logic [ACT_W-1:0]   ACT_RST   = 3'd1;
  localparam logic [SEP_W-1:0]   SEP_RST   = 20'd22282;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEP0      = 3'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] cmd_linear;
    logic signed [FIELD_W-1:0] cmd_angular;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] limited_linear;
    logic signed [FIELD_W-1:0] limited_angular;
  } out_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic div_start;
    logic div_step;
    logic apply_q;
    logic lin_update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic             clip;
    logic [ACT_W-1:0] pairs;
  } sts_t;

endpackage

// ===== rtl/dd_lim_dp.sv =====
// Datapath: config registers, rim speed multiplier, restoring divider, linear rules.
`timescale 1ns / 1ps
module dd_lim_dp #(
  parameter int MAX_PAIRS = dd_lim_pkg::MAX_PAIRS_DEF,
  parameter int PAIR_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dd_lim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dd_lim_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  dd_lim_pkg::in_t                     in_data,
  input  dd_lim_pkg::cmd_t                    cmd,
  input  logic [PAIR_W-1:0]                   pair,
  output dd_lim_pkg::sts_t                    sts,
  output dd_lim_pkg::out_t                    out_data
);
  import dd_lim_pkg::*;

  localparam logic signed [VEL_W-1:0] V_MAX = 30'sd8388607;
  localparam logic signed [VEL_W-1:0] V_MIN = -30'sd8388608;

  logic [SPEED_W-1:0] max_speed;
  logic [ACT_W-1:0]   active;
  logic [SEP_W-1:0]   sep [MAX_PAIRS];

  logic signed [VEL_W-1:0]   v;
  logic signed [FIELD_W-1:0] a;
  logic [RIM_W-1:0]          r;
  logic [SEP_W-1:0]          rem;
  logic [QUO_W-1:0]          quo;
  out_t                      out_q;

  logic [SEP_W-1:0]          sep_cur;
  logic [FIELD_W-1:0]        a_mag;
  logic [43:0]               prod;
  logic signed [VEL_W-1:0]   m_s;
  logic signed [VEL_W-1:0]   neg_m;
  logic signed [VEL_W-1:0]   r_s;
  logic signed [VEL_W-1:0]   vpr;
  logic signed [VEL_W-1:0]   vmr;
  logic signed [VEL_W-1:0]   v_next;
  logic signed [VEL_W-1:0]   lin_ext;
  logic signed [VEL_W-1:0]   lin_clamp;
  logic [SEP_W:0]            rem_sh;
  logic [SEP_W:0]            rem_diff;
  logic                      rem_ge;
  logic [SEP_W-1:0]          rem_next;
  logic [QUO_W-1:0]          quo_next;
  logic signed [FIELD_W-1:0] q_sat;
  logic signed [FIELD_W-1:0] lin_sat;

  assign sep_cur = sep[pair];
  assign a_mag   = a[FIELD_W-1] ? FIELD_W'(-a) : FIELD_W'(a);
  assign prod    = a_mag * sep_cur;

  assign m_s   = {7'b0, max_speed};
  assign neg_m = -m_s;
  assign r_s   = {3'b0, r};
  assign vpr   = v + r_s;
  assign vmr   = v - r_s;

  always_comb begin
    if (vpr > m_s) begin
      v_next = m_s - r_s;
    end else if (vmr > m_s) begin
      v_next = m_s + r_s;
    end else if (vmr < neg_m) begin
      v_next = neg_m + r_s;
    end else if (vpr < neg_m) begin
      v_next = neg_m - r_s;
    end else begin
      v_next = v;
    end
  end

  assign lin_ext = VEL_W'(in_data.cmd_linear);
  always_comb begin
    if (lin_ext > m_s) begin
      lin_clamp = m_s;
    end else if (lin_ext < neg_m) begin
      lin_clamp = neg_m;
    end else begin
      lin_clamp = lin_ext;
    end
  end

  assign rem_sh   = {rem, quo[QUO_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, sep_cur};
  assign rem_diff = rem_sh - {1'b0, sep_cur};
  assign rem_next = rem_ge ? rem_diff[SEP_W-1:0] : rem_sh[SEP_W-1:0];
  assign quo_next = {quo[QUO_W-2:0], rem_ge};

  assign q_sat = (quo[QUO_W-1:FIELD_W-1] != '0) ? 24'sh7FFFFF
                                                : {1'b0, quo[FIELD_W-2:0]};

  always_comb begin
    if (v > V_MAX) begin
      lin_sat = 24'sh7FFFFF;
    end else if (v < V_MIN) begin
      lin_sat = 24'sh800000;
    end else begin
      lin_sat = v[FIELD_W-1:0];
    end
  end

  assign sts.clip  = r > {4'b0, max_speed};
  assign sts.pairs = (active > ACT_W'(MAX_PAIRS)) ? ACT_W'(MAX_PAIRS) : active;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= SPEED_RST;
      active    <= ACT_RST;
      for (int p = 0; p < MAX_PAIRS; p++) begin
        sep[p] <= SEP_RST;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_SPEED) begin
        max_speed <= cfg_data[SPEED_W-1:0];
      end
      if (cfg_index == REG_ACTIVE) begin
        active <= cfg_data[ACT_W-1:0];
      end
      for (int p = 0; p < MAX_PAIRS; p++) begin
        if (cfg_index == REG_SEP0 + CFG_IDX_W'(p)) begin
          sep[p] <= cfg_data[SEP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v <= lin_clamp;
      a <= in_data.cmd_angular;
    end
    if (cmd.mul) begin
      r <= prod[43:FRAC_SHIFT];
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= {max_speed, {FRAC_SHIFT{1'b0}}};
    end
    if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (cmd.apply_q) begin
      a <= a[FIELD_W-1] ? -q_sat : q_sat;
    end
    if (cmd.lin_update) begin
      v <= v_next;
    end
    if (cmd.load_out) begin
      out_q.limited_linear  <= lin_sat;
      out_q.limited_angular <= a;
    end
  end

  assign out_data = out_q;

endmodule

// ===== rtl/dd_lim_ctrl.sv =====
// Controller: sequences the two passes over the wheel pairs and the output register.
`timescale 1ns / 1ps
module dd_lim_ctrl #(
  parameter int MAX_PAIRS = dd_lim_pkg::MAX_PAIRS_DEF,
  parameter int PAIR_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dd_lim_pkg::sts_t  sts,
  output dd_lim_pkg::cmd_t  cmd,
  output logic [PAIR_W-1:0] pair
);
  import dd_lim_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RIM1  = 3'd1;
  localparam logic [2:0] S_CHK1  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_RIM2  = 3'd5;
  localparam logic [2:0] S_LIN   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]           state, state_next;
  logic [PAIR_W-1:0]    pair_next;
  logic [DIV_CNT_W-1:0] cnt, cnt_next;
  logic                 out_valid_next;
  logic                 last;

  assign last     = ACT_W'(pair) == ACT_W'(sts.pairs - ACT_W'(1));
  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    pair_next      = pair;
    cnt_next       = cnt;
    case (state)
      S_IDLE: begin
        pair_next = '0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = (sts.pairs == '0) ? S_DONE : S_RIM1;
        end
      end
      S_RIM1: begin
        cmd.mul    = 1'b1;
        state_next = S_CHK1;
      end
      S_CHK1: begin
        if (sts.clip) begin
          cmd.div_start = 1'b1;
          cnt_next      = '0;
          state_next    = S_DIV;
        end else if (last) begin
          pair_next  = '0;
          state_next = S_RIM2;
        end else begin
          pair_next  = pair + PAIR_W'(1);
          state_next = S_RIM1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply_q = 1'b1;
        if (last) begin
          pair_next  = '0;
          state_next = S_RIM2;
        end else begin
          pair_next  = pair + PAIR_W'(1);
          state_next = S_RIM1;
        end
      end
      S_RIM2: begin
        cmd.mul    = 1'b1;
        state_next = S_LIN;
      end
      S_LIN: begin
        cmd.lin_update = 1'b1;
        if (last) begin
          state_next = S_DONE;
        end else begin
          pair_next  = pair + PAIR_W'(1);
          state_next = S_RIM2;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pair      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pair      <= pair_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/diff_drive_velocity_limiter.sv =====
// From input transfer to result valid, the controller runs a first pass over the active pairs,
// using the 40-step restoring divider for each pair whose rim speed clips, then a second pass.
// A new input is accepted only once the controller is idle again; the next input is taken while the
// result waits in the output register. Reset restores all limits to defaults, no clearing pass.
// Top level: differential drive wheel speed limiter.
`timescale 1ns / 1ps
module diff_drive_velocity_limiter #(
  parameter int MAX_PAIRS = dd_lim_pkg::MAX_PAIRS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dd_lim_pkg::in_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dd_lim_pkg::out_t                  out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dd_lim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dd_lim_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dd_lim_pkg::*;

  localparam int PAIR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  cmd_t              cmd;
  sts_t              sts;
  logic [PAIR_W-1:0] pair;

  assign cfg_ready = 1'b1;

  dd_lim_ctrl #(
    .MAX_PAIRS (MAX_PAIRS),
    .PAIR_W    (PAIR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .pair      (pair)
  );

  dd_lim_dp #(
    .MAX_PAIRS (MAX_PAIRS),
    .PAIR_W    (PAIR_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .pair      (pair),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ===== verif/tb_diff_drive_velocity_limiter.sv =====
// Testbench for the differential drive wheel speed limiter: directed and random checks.
`timescale 1ns / 1ps
module tb_diff_drive_velocity_limiter;
  import dd_lim_pkg::*;

  localparam int N_PAIRS = MAX_PAIRS_DEF;
  localparam longint FIELD_HI = 64'sd8388607;
  localparam longint FIELD_LO = -64'sd8388608;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 150;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // mirror of the limit registers
  logic [SPEED_W-1:0] lim_speed = SPEED_RST;
  logic [ACT_W-1:0] lim_pairs = ACT_RST;
  logic [SEP_W-1:0] lim_sep [N_PAIRS];

  out_t limits_due[$];
  out_t want_out;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int ready_gap = 0;
  bit no_idle = 1'b0;

  diff_drive_velocity_limiter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_field(longint x);
    if (x > FIELD_HI) x = FIELD_HI;
    if (x < FIELD_LO) x = FIELD_LO;
    return x[FIELD_W-1:0];
  endfunction

  function automatic longint rim_of(longint ang, logic [SEP_W-1:0] sep);
    longint mag;
    mag = (ang < 0) ? -ang : ang;
    return (mag * longint'(sep)) >>> FRAC_SHIFT;
  endfunction

  function automatic longint clip_edge(longint speed, longint sep);
    return (sep == 0) ? speed : (speed <<< FRAC_SHIFT) / sep;
  endfunction

  function automatic out_t predict_limits(in_t c);
    longint m, v, a, r, q;
    int n, i;
    out_t o;
    m = longint'(lim_speed);
    v = c.cmd_linear;
    a = c.cmd_angular;
    n = (lim_pairs > N_PAIRS) ? N_PAIRS : int'(lim_pairs);
    if (v > m) v = m;
    if (v < -m) v = -m;
    for (i = 0; i < n; i++) begin
      r = rim_of(a, lim_sep[i]);
      if (lim_sep[i] != 0 && r > m) begin
        q = (m <<< FRAC_SHIFT) / longint'(lim_sep[i]);
        if (q > FIELD_HI) q = FIELD_HI;
        a = (a < 0) ? -q : q;
      end
    end
    for (i = 0; i < n; i++) begin
      r = rim_of(a, lim_sep[i]);
      if (v + r > m) v = m - r;
      else if (v - r > m) v = m + r;
      else if (v - r < -m) v = -m + r;
      else if (v + r < -m) v = -m - r;
    end
    o.limited_linear = sat_field(v);
    o.limited_angular = sat_field(a);
    return o;
  endfunction

  // values spread around a span of interest, plus full range and extremes
  function automatic logic signed [FIELD_W-1:0] pick_value(longint span);
    logic [31:0] w;
    if (span > FIELD_HI) span = FIELD_HI;
    case ($urandom_range(0, 4))
      0: begin
        w = $urandom;
        return w[FIELD_W-1:0];
      end
      1: return sat_field(longint'($urandom_range(0, 2 * span)) - span);
      2: return sat_field(($urandom_range(0, 1) ? span : -span) +
                          longint'($urandom_range(0, 4)) - 2);
      3: return sat_field(longint'($urandom_range(0, 64)) - 32);
      default: begin
        case ($urandom_range(0, 2))
          0: return sat_field(FIELD_HI);
          1: return sat_field(FIELD_LO);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic send_cmd(input logic signed [FIELD_W-1:0] lin,
                          input logic signed [FIELD_W-1:0] ang);
    in_t c;
    int gap;
    c.cmd_linear = lin;
    c.cmd_angular = ang;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    limits_due = {limits_due, predict_limits(c)};
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (limits_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MAX_SPEED) lim_speed = val[SPEED_W-1:0];
    else if (idx == REG_ACTIVE) lim_pairs = val[ACT_W-1:0];
    else if (idx >= REG_SEP0 && int'(idx) < int'(REG_SEP0) + N_PAIRS)
      lim_sep[idx - REG_SEP0] = val[SEP_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] speed_w, pairs_w,
                            input logic [CFG_DATA_W-1:0] s0, s1, s2, s3);
    wait_idle();
    write_reg(REG_MAX_SPEED, speed_w);
    write_reg(REG_ACTIVE, pairs_w);
    write_reg(REG_SEP0, s0);
    write_reg(REG_SEP0 + CFG_IDX_W'(1), s1);
    write_reg(REG_SEP0 + CFG_IDX_W'(2), s2);
    write_reg(REG_SEP0 + CFG_IDX_W'(3), s3);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_sep_word();
    logic [31:0] w;
    int p;
    w = $urandom;
    p = $urandom_range(99);
    if (p < 6) w[SEP_W-1:0] = '0;
    else if (p < 12) w[SEP_W-1:0] = '1;
    else if (p < 20) w[SEP_W-1:0] = 20'd655;
    else if (p < 28) w[SEP_W-1:0] = 20'd655360;
    else w[SEP_W-1:0] = SEP_W'($urandom_range(655, 655360));
    return w[CFG_DATA_W-1:0];
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (ready_gap > 0) begin
      out_ready <= 1'b0;
      ready_gap--;
    end else begin
      out_ready <= 1'b1;
      ready_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (limits_due.size() == 0) begin
        $display("%0t: result with none expected: linear %0d angular %0d", $time,
                 out_data.limited_linear, out_data.limited_angular);
        mismatches++;
      end else begin
        want_out = limits_due.pop_front();
        if (out_data.limited_linear !== want_out.limited_linear) begin
          $display("%0t: limited_linear expected %0d got %0d", $time,
                   want_out.limited_linear, out_data.limited_linear);
          mismatches++;
        end
        if (out_data.limited_angular !== want_out.limited_angular) begin
          $display("%0t: limited_angular expected %0d got %0d", $time,
                   want_out.limited_angular, out_data.limited_angular);
          mismatches++;
        end
      end
    end
  end

  task automatic test_defaults();
    longint edge_ang;
    edge_ang = clip_edge(SPEED_RST, SEP_RST);
    send_cmd('0, '0);
    send_cmd(sat_field(FIELD_HI), sat_field(FIELD_HI));
    send_cmd(sat_field(FIELD_LO), sat_field(FIELD_LO));
    send_cmd(sat_field(FIELD_HI), sat_field(FIELD_LO));
    send_cmd(sat_field(SPEED_RST), sat_field(edge_ang));
    send_cmd(sat_field(-longint'(SPEED_RST)), sat_field(-edge_ang - 1));
    send_cmd(sat_field(1), sat_field(edge_ang + 1));
  endtask

  task automatic test_register_extremes();
    set_limits(23'h7FFFFF, 23'd4, 23'd655, 23'd655360, 23'd655, 23'd655360);
    send_cmd(sat_field(FIELD_HI), sat_field(FIELD_HI));
    send_cmd(sat_field(FIELD_LO), sat_field(FIELD_LO));
    send_cmd(sat_field(FIELD_LO), sat_field(1));
    set_limits(23'd1, 23'd4, 23'd655360, 23'd655360, 23'd655360, 23'd655360);
    send_cmd(sat_field(FIELD_HI), sat_field(FIELD_LO));
    send_cmd(sat_field(-1), sat_field(3));
    send_cmd(sat_field(2), sat_field(-2));
  endtask

  task automatic test_special_cases();
    // no pairs: linear clamp only
    set_limits(23'd65536, 23'd0, 23'd22282, 23'd22282, 23'd22282, 23'd22282);
    send_cmd(sat_field(FIELD_HI), sat_field(FIELD_HI));
    send_cmd(sat_field(-100000), sat_field(FIELD_LO));
    // pair count above the maximum
    wait_idle();
    write_reg(REG_ACTIVE, 23'd7);
    send_cmd(sat_field(30000), sat_field(900000));
    wait_idle();
    write_reg(REG_ACTIVE, 23'd5);
    send_cmd(sat_field(-30000), sat_field(-900000));
    // zero separation never clips
    set_limits(23'd65536, 23'd4, 23'd0, 23'd22282, 23'd0, 23'd655);
    send_cmd(sat_field(FIELD_HI), sat_field(FIELD_HI));
    send_cmd(sat_field(-70000), sat_field(-500000));
    // zero speed limit
    set_limits(23'd0, 23'd2, 23'd22282, 23'd100000, 23'd22282, 23'd22282);
    send_cmd(sat_field(5), sat_field(FIELD_LO));
    send_cmd(sat_field(FIELD_LO), '0);
    // upper bits of narrow registers dropped
    wait_idle();
    write_reg(REG_ACTIVE, 23'h7FFFFA);
    write_reg(REG_SEP0, 23'h7FFFFF);
    write_reg(REG_SEP0 + CFG_IDX_W'(1), 23'h500000 | 23'd655);
    write_reg(REG_MAX_SPEED, 23'd200000);
    send_cmd(sat_field(150000), sat_field(FIELD_HI));
    send_cmd(sat_field(-190000), sat_field(-40000));
    // unused indexes leave the registers alone
    wait_idle();
    write_reg(REG_SPARE_LO, 23'h7FFFFF);
    write_reg(REG_SPARE_HI, 23'h000000);
    send_cmd(sat_field(150000), sat_field(FIELD_HI));
    send_cmd(sat_field(-190000), sat_field(-40000));
  endtask

  task automatic test_back_pressure();
    int i;
    set_limits(23'd131072, 23'd4, pick_sep_word(), pick_sep_word(), pick_sep_word(),
               pick_sep_word());
    hold_left = 1000;
    for (i = 0; i < 8; i++)
      send_cmd(pick_value(lim_speed), pick_value(clip_edge(lim_speed, lim_sep[0])));
  endtask

  task automatic test_random();
    int ph, i;
    logic [CFG_DATA_W-1:0] speed_w, pairs_w;
    logic [31:0] w;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        set_limits(23'h7FFFFF, 23'd4, 23'd655, 23'd655, 23'd655, 23'd655);
      end else if (ph == 1) begin
        set_limits(23'd1, 23'd4, 23'd655360, 23'd655360, 23'd655360, 23'd655360);
      end else begin
        case ($urandom_range(0, 9))
          0: speed_w = '0;
          1: speed_w = 23'd1;
          2: speed_w = 23'h7FFFFF;
          default: speed_w = CFG_DATA_W'($urandom_range(1, 6553600));
        endcase
        w = $urandom;
        w[ACT_W-1:0] = ($urandom_range(0, 9) < 8) ? ACT_W'($urandom_range(1, 4))
                                                  : ACT_W'($urandom_range(0, 7));
        pairs_w = w[CFG_DATA_W-1:0];
        set_limits(speed_w, pairs_w, pick_sep_word(), pick_sep_word(), pick_sep_word(),
                   pick_sep_word());
        if ($urandom_range(0, 1)) begin
          w = $urandom;
          write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, w[CFG_DATA_W-1:0]);
        end
      end
      no_idle = (ph == 3);
      for (i = 0; i < PHASE_ITEMS; i++)
        send_cmd(pick_value(lim_speed),
                 pick_value(clip_edge(lim_speed, lim_sep[$urandom_range(0, N_PAIRS - 1)])));
      no_idle = 1'b0;
    end
  endtask

  initial begin
    for (int k = 0; k < N_PAIRS; k++) lim_sep[k] = SEP_RST;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_register_extremes();
    test_special_cases();
    test_back_pressure();
    test_random();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && limits_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dd_lim_pkg.sv
rtl/dd_lim_dp.sv
rtl/dd_lim_ctrl.sv
rtl/diff_drive_velocity_limiter.sv
verif/tb_diff_drive_velocity_limiter.sv
